[src/gpc_pkg.sv]
package gpc_pkg;

    localparam int OPCODE_W = 2;
    localparam int ROW_IN_W = 5;
    localparam int COL_IN_W = 5;
    localparam int WEIGHT_W = 4;
    localparam int CELL_W   = WEIGHT_W + 1;
    localparam int TOTAL_W  = 16;

    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SOLVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // A cell word holds the wall flag above the step weight.
    localparam logic [CELL_W-1:0] CELL_WALL = 5'b10000;

    typedef struct packed {
        logic load_own;
        logic take_nb;
        logic nb_in_grid;
    } gpc_relax_ctl_t;

endpackage

[src/gpc_if.sv]
interface gpc_req_if;
    import gpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [ROW_IN_W-1:0] row_index;
    logic [COL_IN_W-1:0] col_index;
    logic [WEIGHT_W-1:0] step_weight;
    logic                is_wall;

    modport source (output valid, opcode, row_index, col_index, step_weight, is_wall,
                    input ready);
    modport sink (input valid, opcode, row_index, col_index, step_weight, is_wall,
                  output ready);
endinterface

interface gpc_rsp_if;
    import gpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_cost;
    logic               reachable;

    modport source (output valid, total_cost, reachable, input ready);
    modport sink (input valid, total_cost, reachable, output ready);
endinterface

[src/gpc_ram.sv]
module gpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/gpc_relax.sv]
module gpc_relax #(
    parameter int COST_BITS = 16
) (
    input  logic                   clk,
    input  gpc_pkg::gpc_relax_ctl_t ctl,
    input  logic [gpc_pkg::CELL_W-1:0] cell_word,
    input  logic [COST_BITS-1:0]   cost_rd,
    output logic [COST_BITS-1:0]   best,
    output logic                   improved,
    output logic                   cell_open
);
    import gpc_pkg::*;

    localparam logic [COST_BITS-1:0] UNREACH = '1;
    localparam logic [COST_BITS-1:0] LIMIT   = UNREACH - 1'b1;

    logic [COST_BITS-1:0] own_reg;
    logic [COST_BITS-1:0] best_reg;
    logic [CELL_W-1:0]    cell_reg;
    logic [COST_BITS:0]   sum;
    logic [COST_BITS-1:0] cand;

    // Candidate is the neighbor cost plus this cell's weight, saturated below unreachable.
    always_comb
    begin
        sum  = {1'b0, cost_rd} + (COST_BITS+1)'(cell_reg[WEIGHT_W-1:0]);
        cand = (sum > {1'b0, LIMIT}) ? LIMIT : sum[COST_BITS-1:0];
        best = best_reg;
        if (ctl.take_nb && ctl.nb_in_grid && cost_rd != UNREACH && cand < best_reg)
        begin
            best = cand;
        end
    end

    assign improved  = best < own_reg;
    assign cell_open = ~cell_reg[CELL_W-1];

    always_ff @(posedge clk)
    begin
        if (ctl.load_own)
        begin
            own_reg  <= cost_rd;
            best_reg <= cost_rd;
            cell_reg <= cell_word;
        end
        else
        begin
            best_reg <= best;
        end
    end

endmodule

[src/grid_path_cost_relaxation.sv]
// Load and unknown-opcode words return their result in the cycle after they are accepted.
// Read words pass through one cost memory read, then the output register.
// Solve words are paced by the single relax unit and the one read port of the cost memory;
// sweeps repeat until none changes.
// After reset a clearing pass over all CELLS = GRID_ROWS * GRID_COLS cells marks every cell
// a wall and unreachable; ready stays low during that pass.
module grid_path_cost_relaxation #(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 32,
    parameter int COST_BITS = 16
) (
    input logic     clk,
    input logic     rst_n,
    gpc_req_if.sink req,
    gpc_rsp_if.source rsp
);
    import gpc_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int CAW   = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);

    localparam logic [CAW-1:0] LAST_IDX = CAW'(CELLS - 1);
    localparam logic [CAW-1:0] COL_STEP = CAW'(GRID_COLS);
    localparam logic [RW-1:0]  LAST_ROW = RW'(GRID_ROWS - 1);
    localparam logic [CW-1:0]  LAST_COL = CW'(GRID_COLS - 1);
    localparam logic [COST_BITS-1:0] UNREACH = '1;

    localparam logic [2:0] K_OWN   = 3'd0;
    localparam logic [2:0] K_LEFT  = 3'd1;
    localparam logic [2:0] K_RIGHT = 3'd2;
    localparam logic [2:0] K_UP    = 3'd3;
    localparam logic [2:0] K_DOWN  = 3'd4;
    localparam logic [2:0] K_LAST  = 3'd5;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_START,
        S_SWEEP,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic [CAW-1:0] idx_reg, idx_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [2:0]     k_reg, k_next;
    logic           changed_reg, changed_next;
    logic [CAW-1:0] start_idx_reg, start_idx_next;
    logic           start_ok_reg, start_ok_next;
    logic           read_ok_reg, read_ok_next;
    logic           out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] out_cost_reg, out_cost_next;
    logic           out_reach_reg, out_reach_next;

    logic [31:0]    req_lin;
    logic [CAW-1:0] req_idx;
    logic           req_inside;
    logic           in_ready;
    logic           accept;
    logic [31:0]    cost_ext;
    logic           wr_cell;

    logic                 w_we;
    logic [CAW-1:0]       w_waddr;
    logic [CELL_W-1:0]    w_wdata;
    logic [CELL_W-1:0]    w_rdata;
    logic                 c_we;
    logic [CAW-1:0]       c_waddr;
    logic [COST_BITS-1:0] c_wdata;
    logic [COST_BITS-1:0] c_rdata;
    logic [CAW-1:0]       raddr;

    gpc_relax_ctl_t       ctl;
    logic [COST_BITS-1:0] best;
    logic                 improved;
    logic                 cell_open;

    gpc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (raddr),
        .rdata (w_rdata)
    );

    gpc_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (CELLS)
    ) u_cost_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (raddr),
        .rdata (c_rdata)
    );

    gpc_relax #(
        .COST_BITS (COST_BITS)
    ) u_relax (
        .clk       (clk),
        .ctl       (ctl),
        .cell_word (w_rdata),
        .cost_rd   (c_rdata),
        .best      (best),
        .improved  (improved),
        .cell_open (cell_open)
    );

    assign req_lin    = 32'(req.row_index) * 32'(GRID_COLS) + 32'(req.col_index);
    assign req_idx    = req_lin[CAW-1:0];
    assign req_inside = (32'(req.row_index) < 32'(GRID_ROWS))
                        && (32'(req.col_index) < 32'(GRID_COLS));
    assign in_ready   = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && in_ready;
    assign cost_ext   = 32'(c_rdata);

    assign req.ready      = in_ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.total_cost = out_cost_reg;
    assign rsp.reachable  = out_reach_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        k_next         = k_reg;
        changed_next   = changed_reg;
        start_idx_next = start_idx_reg;
        start_ok_next  = start_ok_reg;
        read_ok_next   = read_ok_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_cost_next  = out_cost_reg;
        out_reach_next = out_reach_reg;

        w_we    = 1'b0;
        w_waddr = idx_reg;
        w_wdata = CELL_WALL;
        c_we    = 1'b0;
        c_waddr = idx_reg;
        c_wdata = UNREACH;
        raddr   = idx_reg;
        ctl     = '0;
        wr_cell = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                w_we = 1'b1;
                c_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                raddr   = req_idx;
                w_waddr = req_idx;
                w_wdata = {req.is_wall, req.step_weight};
                if (accept)
                begin
                    unique case (req.opcode)
                        OP_LOAD:
                        begin
                            w_we           = req_inside;
                            out_valid_next = 1'b1;
                            out_cost_next  = '0;
                            out_reach_next = 1'b0;
                        end
                        OP_SOLVE:
                        begin
                            start_idx_next = req_idx;
                            start_ok_next  = req_inside;
                            idx_next       = '0;
                            state_next     = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            read_ok_next = req_inside;
                            state_next   = S_READ;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_cost_next  = '0;
                            out_reach_next = 1'b0;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                out_valid_next = 1'b1;
                out_reach_next = read_ok_reg && (c_rdata != UNREACH);
                if (!out_reach_next)
                begin
                    out_cost_next = '0;
                end
                else if (cost_ext > 32'(16'hFFFF))
                begin
                    out_cost_next = '1;
                end
                else
                begin
                    out_cost_next = cost_ext[TOTAL_W-1:0];
                end
                state_next = S_IDLE;
            end

            S_CLEAR:
            begin
                c_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = start_ok_reg ? S_START : S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_START:
            begin
                c_we         = 1'b1;
                c_waddr      = start_idx_reg;
                c_wdata      = '0;
                idx_next     = '0;
                row_next     = '0;
                col_next     = '0;
                k_next       = K_OWN;
                changed_next = 1'b0;
                state_next   = S_SWEEP;
            end

            S_SWEEP:
            begin
                case (k_reg)
                    K_LEFT:  raddr = (col_reg != '0) ? idx_reg - 1'b1 : idx_reg;
                    K_RIGHT: raddr = (col_reg != LAST_COL) ? idx_reg + 1'b1 : idx_reg;
                    K_UP:    raddr = (row_reg != '0) ? idx_reg - COL_STEP : idx_reg;
                    K_DOWN:  raddr = (row_reg != LAST_ROW) ? idx_reg + COL_STEP : idx_reg;
                    default: raddr = idx_reg;
                endcase

                ctl.load_own = (k_reg == K_LEFT);
                ctl.take_nb  = (k_reg != K_OWN) && (k_reg != K_LEFT);
                case (k_reg)
                    K_RIGHT: ctl.nb_in_grid = (col_reg != '0);
                    K_UP:    ctl.nb_in_grid = (col_reg != LAST_COL);
                    K_DOWN:  ctl.nb_in_grid = (row_reg != '0);
                    K_LAST:  ctl.nb_in_grid = (row_reg != LAST_ROW);
                    default: ctl.nb_in_grid = 1'b0;
                endcase

                if (k_reg == K_LAST)
                begin
                    wr_cell      = cell_open && improved;
                    c_we         = wr_cell;
                    c_wdata      = best;
                    changed_next = changed_reg || wr_cell;
                    k_next       = K_OWN;
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next = '0;
                        row_next = '0;
                        col_next = '0;
                        if (changed_next)
                        begin
                            changed_next = 1'b0;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (col_reg == LAST_COL)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            S_FINISH:
            begin
                out_valid_next = 1'b1;
                out_cost_next  = '0;
                out_reach_next = 1'b0;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= K_OWN;
            changed_reg   <= 1'b0;
            start_idx_reg <= '0;
            start_ok_reg  <= 1'b0;
            read_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_cost_reg  <= '0;
            out_reach_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            k_reg         <= k_next;
            changed_reg   <= changed_next;
            start_idx_reg <= start_idx_next;
            start_ok_reg  <= start_ok_next;
            read_ok_reg   <= read_ok_next;
            out_valid_reg <= out_valid_next;
            out_cost_reg  <= out_cost_next;
            out_reach_reg <= out_reach_next;
        end
    end

endmodule
